[src/bfio_pkg.sv]
// Shared constants, types and helpers for the backlight fade and idle-off block.
package bfio_pkg;

  localparam int unsigned LevelW   = 7;
  localparam int unsigned ReqW     = 8;
  localparam int unsigned CountW   = 17;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned OpW      = 3;

  localparam logic [LevelW-1:0]   LevelMax       = LevelW'(100);
  localparam logic [TimeoutW-1:0] IdleTimeoutRst = TimeoutW'(30);
  localparam logic [CountW-1:0]   CountOff       = {CountW{1'b1}};

  localparam longint unsigned DutyMax    = 1023;
  localparam int unsigned     RecipShift = 30;
  localparam longint unsigned RecipK     = ((64'd1 << RecipShift) + 64'd99) / 64'd100;
  localparam int unsigned     DutyScaleW = 48;
  localparam logic [DutyScaleW-1:0] DutyScale = DutyScaleW'(DutyMax * RecipK);

  typedef enum logic [OpW-1:0] {
    OpFade     = 3'd0,
    OpSecond   = 3'd1,
    OpSetLevel = 3'd2,
    OpActivity = 3'd3,
    OpKeepOn   = 3'd4
  } bfio_op_e;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] target;
    logic              ramp_up;
    logic              ramp_running;
    logic [CountW-1:0] countdown;
    logic [LevelW-1:0] remembered;
  } bfio_state_t;

  // level * DutyMax / 100 via fixed-point reciprocal, low DutyW bits
  function automatic logic [DutyW-1:0] duty_of(logic [LevelW-1:0] lvl);
    logic [DutyScaleW+LevelW-1:0] prod;
    prod = {{LevelW{1'b0}}, DutyScale} * {{DutyScaleW{1'b0}}, lvl};
    return prod[RecipShift +: DutyW];
  endfunction

endpackage

[src/bfio_in_if.sv]
// Input event channel: valid/ready handshake with event payload.
interface bfio_in_if;
  import bfio_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ReqW-1:0]   new_level;
  logic              lock_cur;

  modport source (output valid, opcode, new_level, lock_cur, input ready);
  modport sink   (input valid, opcode, new_level, lock_cur, output ready);
endinterface

[src/bfio_out_if.sv]
// Result channel: valid/ready handshake with duty, level and countdown.
interface bfio_out_if;
  import bfio_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DutyW-1:0]         pwm_duty;
  logic [LevelW-1:0]        level_now;
  logic                     fading;
  logic signed [CountW-1:0] seconds_left;

  modport source (output valid, pwm_duty, level_now, fading, seconds_left, input ready);
  modport sink   (input valid, pwm_duty, level_now, fading, seconds_left, output ready);
endinterface

[src/bfio_update.sv]
// Next-state logic for one event.
module bfio_update
  import bfio_pkg::*;
(
  input  bfio_state_t         state_i,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [ReqW-1:0]     new_level_i,
  input  logic                lock_cur_i,
  input  logic [TimeoutW-1:0] idle_timeout_i,
  output bfio_state_t         state_o
);

  function automatic bfio_state_t set_level(bfio_state_t s, logic [LevelW-1:0] req,
                                            logic lock);
    bfio_state_t r;
    r = s;
    if (req != s.level) begin
      r.remembered   = lock ? s.level : req;
      r.target       = req;
      r.ramp_up      = (req > s.level);
      r.ramp_running = 1'b1;
    end
    return r;
  endfunction

  logic [LevelW-1:0] req_clamped;
  logic [LevelW-1:0] stepped;
  bfio_state_t       s;

  assign req_clamped = (new_level_i > {1'b0, LevelMax}) ? LevelMax : new_level_i[LevelW-1:0];

  always_comb begin
    if (state_i.ramp_up) begin
      stepped = (state_i.level < LevelMax) ? state_i.level + 1'b1 : state_i.level;
    end else begin
      stepped = (state_i.level != '0) ? state_i.level - 1'b1 : state_i.level;
    end
  end

  always_comb begin
    s = state_i;
    unique case (bfio_op_e'(opcode_i))
      OpFade: begin
        if (s.ramp_running) begin
          if (s.level == s.target) begin
            s.ramp_running = 1'b0;
          end else begin
            s.level = stepped;
            if (stepped == s.target) begin
              s.ramp_running = 1'b0;
            end
          end
        end
      end
      OpSecond: begin
        if (s.countdown != CountOff) begin
          if (s.countdown == '0) begin
            s = set_level(s, '0, 1'b1);
          end
          s.countdown = s.countdown - 1'b1;
        end
      end
      OpSetLevel: begin
        s = set_level(s, req_clamped, lock_cur_i);
      end
      OpActivity: begin
        if (s.countdown == CountOff) begin
          s = set_level(s, s.remembered, 1'b0);
        end
        s.countdown = {1'b0, idle_timeout_i};
      end
      OpKeepOn: begin
        s = set_level(s, s.remembered, 1'b0);
        s.countdown = CountOff;
      end
      default: begin
        s = state_i;
      end
    endcase
  end

  assign state_o = s;

endmodule

[src/backlight_fade_and_idle_off_core.sv]
// Top level of the backlight dimmer with fade ramp and idle auto-off.
// Output: each result is registered and is valid in the cycle after its event transaction.
// Throughput: one event per cycle while the sink takes results; the result register frees as it is taken.
// Ready drops only while a result is held and the sink stalls.
// Reset: level, target, ramp and remembered level clear, countdown disabled,
// idle timeout 30 s; no result pending.
module backlight_fade_and_idle_off_core
  import bfio_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bfio_in_if.sink             in_i,
  bfio_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i
);

  logic [TimeoutW-1:0] idle_timeout_q;
  bfio_state_t         state_q, state_d;
  logic                out_valid_q;
  logic [DutyW-1:0]    duty_q;
  logic [LevelW-1:0]   level_q;
  logic                fading_q;
  logic [CountW-1:0]   secs_q;
  logic                accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  bfio_update u_update (
    .state_i        (state_q),
    .opcode_i       (in_i.opcode),
    .new_level_i    (in_i.new_level),
    .lock_cur_i     (in_i.lock_cur),
    .idle_timeout_i (idle_timeout_q),
    .state_o        (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      idle_timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{level: '0, target: '0, ramp_up: 1'b0, ramp_running: 1'b0,
                   countdown: CountOff, remembered: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      duty_q   <= duty_of(state_d.level);
      level_q  <= state_d.level;
      fading_q <= state_d.ramp_running;
      secs_q   <= state_d.countdown;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pwm_duty     = duty_q;
  assign out_o.level_now    = level_q;
  assign out_o.fading       = fading_q;
  assign out_o.seconds_left = $signed(secs_q);

endmodule

[src/bfio_checker.sv]
// Port-level assertions for the backlight core, bound to the top level.
module bfio_checker
  import bfio_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [DutyW-1:0]         pwm_duty_i,
  input logic [LevelW-1:0]        level_now_i,
  input logic signed [CountW-1:0] seconds_left_i
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after transaction");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> level_now_i <= LevelMax)
    else $error("level above 100");

  a_dark_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && level_now_i == '0 |-> pwm_duty_i == '0)
    else $error("nonzero duty at level 0");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(seconds_left_i))
    else $error("stalled result changed");

endmodule

bind backlight_fade_and_idle_off_core bfio_checker u_bfio_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pwm_duty_i     (out_o.pwm_duty),
  .level_now_i    (out_o.level_now),
  .seconds_left_i (out_o.seconds_left)
);

[sim/backlight_fade_and_idle_off_core_tb.sv]
// Testbench for the backlight dimmer core: random handshakes, inline predictor, scoreboard.
`timescale 1ns / 100ps

module backlight_fade_and_idle_off_core_tb;
  import bfio_pkg::*;

  localparam logic [OpW-1:0] OpRsvd5 = 3'd5;
  localparam logic [OpW-1:0] OpRsvd6 = 3'd6;
  localparam logic [OpW-1:0] OpRsvd7 = 3'd7;
  localparam int unsigned    StallLimit = 2000;
  localparam int             CountOffInt = -1;

  typedef struct {
    logic [DutyW-1:0]  duty;
    logic [LevelW-1:0] lvl;
    logic              fading;
    logic [CountW-1:0] secs;
  } bl_reading_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TimeoutW-1:0] cfg_wdata_i;

  bfio_in_if  ev_if ();
  bfio_out_if rd_if ();

  backlight_fade_and_idle_off_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (ev_if),
    .out_o       (rd_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // dimmer prediction state
  logic [LevelW-1:0]   dim_level;
  logic [LevelW-1:0]   dim_target;
  logic                dim_up;
  logic                dim_running;
  int                  dim_count;
  logic [LevelW-1:0]   dim_saved;
  logic                dim_keep;
  logic [TimeoutW-1:0] dim_timeout;

  bl_reading_t pending_readings[$];
  int unsigned err_cnt;
  int unsigned stall_cycles;
  bit          ev_steady;
  bit          rd_steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic void dim_request(input logic [ReqW-1:0] req, input logic lock);
    logic [LevelW-1:0] r;
    r = (req > ReqW'(LevelMax)) ? LevelMax : req[LevelW-1:0];
    if (r == dim_level) return;
    dim_saved   = lock ? dim_level : r;
    dim_target  = r;
    dim_up      = (r > dim_level);
    dim_running = 1'b1;
  endfunction

  function automatic bl_reading_t dimmer_step(input logic [OpW-1:0] op,
                                              input logic [ReqW-1:0] req,
                                              input logic lock);
    bl_reading_t rd;
    int unsigned duty;
    case (op)
      OpFade: begin
        if (dim_running) begin
          if (dim_level == dim_target) begin
            dim_running = 1'b0;
          end else begin
            if (dim_up) begin
              if (dim_level < LevelMax) dim_level = dim_level + 1'b1;
            end else begin
              if (dim_level > 0) dim_level = dim_level - 1'b1;
            end
            if (dim_level == dim_target) dim_running = 1'b0;
          end
        end
      end
      OpSecond: begin
        if (dim_count != CountOffInt) begin
          if (dim_count == 0) dim_request('0, 1'b1);
          dim_count = dim_count - 1;
        end
      end
      OpSetLevel: dim_request(req, lock);
      OpActivity: begin
        if (dim_count == CountOffInt) dim_request(ReqW'(dim_saved), 1'b0);
        dim_count = int'(dim_timeout);
        dim_keep  = 1'b0;
      end
      OpKeepOn: begin
        dim_request(ReqW'(dim_saved), 1'b0);
        dim_count = CountOffInt;
        dim_keep  = 1'b1;
      end
      default: ;
    endcase
    duty      = (int'(DutyMax) * int'(dim_level)) / 100;
    rd.duty   = duty[DutyW-1:0];
    rd.lvl    = dim_level;
    rd.fading = dim_running;
    rd.secs   = dim_count[CountW-1:0];
    return rd;
  endfunction

  task automatic send_event(input logic [OpW-1:0] op, input logic [ReqW-1:0] req,
                            input logic lock);
    int unsigned gap;
    gap = ev_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid     <= 1'b1;
    ev_if.opcode    <= op;
    ev_if.new_level <= req;
    ev_if.lock_cur  <= lock;
    @(posedge clk_i);
    while (!ev_if.ready) @(posedge clk_i);
    pending_readings.push_back(dimmer_step(op, req, lock));
  endtask

  task automatic drain_results();
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TimeoutW-1:0] secs);
    ev_if.valid <= 1'b0;
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= secs;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dim_timeout = secs;
  endtask

  // result checker
  initial begin
    bl_reading_t want;
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rd_steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        rd_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rd_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rd_if.valid) @(posedge clk_i);
      if (pending_readings.size() == 0) begin
        flag_error("result transaction with nothing expected");
      end else begin
        want = pending_readings.pop_front();
        if (want.duty !== rd_if.pwm_duty)
          flag_error($sformatf("pwm_duty exp %0d got %0d", want.duty, rd_if.pwm_duty));
        if (want.lvl !== rd_if.level_now)
          flag_error($sformatf("level_now exp %0d got %0d", want.lvl, rd_if.level_now));
        if (want.fading !== rd_if.fading)
          flag_error($sformatf("fading exp %0b got %0b", want.fading, rd_if.fading));
        if (want.secs !== rd_if.seconds_left)
          flag_error($sformatf("seconds_left exp %h got %h", want.secs, rd_if.seconds_left));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (rd_if.valid && rd_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("backlight_fade_and_idle_off_core_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_idle_events();
    send_event(OpFade, 8'd0, 1'b0);
    send_event(OpSecond, 8'hFF, 1'b1);
    send_event(OpRsvd5, 8'h55, 1'b1);
    send_event(OpRsvd6, 8'hAA, 1'b0);
    send_event(OpRsvd7, 8'hFF, 1'b1);
    send_event(OpActivity, 8'd0, 1'b0);
    send_event(OpKeepOn, 8'd0, 1'b0);
  endtask

  task automatic test_set_level();
    send_event(OpSetLevel, 8'd255, 1'b0);
    send_event(OpSetLevel, 8'd0, 1'b0);
    send_event(OpFade, 8'd0, 1'b0);
    send_event(OpFade, 8'd0, 1'b0);
    send_event(OpSetLevel, 8'd2, 1'b1);
    send_event(OpSetLevel, 8'd1, 1'b1);
    send_event(OpFade, 8'd0, 1'b0);
    send_event(OpFade, 8'd0, 1'b0);
  endtask

  task automatic test_idle_expiry();
    write_timeout('0);
    send_event(OpActivity, 8'd0, 1'b0);
    send_event(OpSecond, 8'd0, 1'b0);
    send_event(OpFade, 8'd0, 1'b0);
    send_event(OpKeepOn, 8'd0, 1'b0);
    send_event(OpActivity, 8'd0, 1'b0);
    send_event(OpSecond, 8'd0, 1'b0);
    send_event(OpFade, 8'd0, 1'b0);
    write_timeout('1);
    send_event(OpActivity, 8'd0, 1'b0);
    send_event(OpSecond, 8'd0, 1'b0);
    send_event(OpSetLevel, 8'd100, 1'b1);
  endtask

  task automatic run_random(input logic [TimeoutW-1:0] secs, input int unsigned n);
    int unsigned pick;
    logic [OpW-1:0]  op;
    logic [ReqW-1:0] req;
    write_timeout(secs);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        ev_steady = ($urandom_range(0, 3) == 0);
        rd_steady = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = OpFade;
      else if (pick < 58) op = OpSecond;
      else if (pick < 76) op = OpSetLevel;
      else if (pick < 88) op = OpActivity;
      else if (pick < 95) op = OpKeepOn;
      else                op = OpW'($urandom_range(5, 7));
      case ($urandom_range(0, 3))
        0:       req = ReqW'(dim_level);
        1:       req = ReqW'($urandom_range(101, 255));
        default: req = ReqW'($urandom_range(0, 100));
      endcase
      send_event(op, req, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_phases();
    run_random(16'd0, 150);
    run_random(16'd1, 150);
    run_random(16'd3, 150);
    run_random(16'hFFFF, 100);
    run_random(IdleTimeoutRst, 150);
    run_random(TimeoutW'($urandom_range(0, 6)), 150);
    run_random(TimeoutW'($urandom_range(0, 65535)), 50);
    run_random(16'd2, 150);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    ev_if.valid     <= 1'b0;
    ev_if.opcode    <= '0;
    ev_if.new_level <= '0;
    ev_if.lock_cur  <= 1'b0;
    rd_if.ready     <= 1'b0;
    err_cnt      = 0;
    stall_cycles = 0;
    ev_steady    = 1'b0;
    rd_steady    = 1'b0;
    dim_level    = '0;
    dim_target   = '0;
    dim_up       = 1'b0;
    dim_running  = 1'b0;
    dim_count    = CountOffInt;
    dim_saved    = '0;
    dim_keep     = 1'b0;
    dim_timeout  = IdleTimeoutRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_events();
    test_set_level();
    test_idle_expiry();
    test_random_phases();

    ev_if.valid <= 1'b0;
    drain_results();
    if (err_cnt == 0) begin
      $display("backlight_fade_and_idle_off_core_tb: done, clean");
    end else begin
      $display("backlight_fade_and_idle_off_core_tb: done, errors");
    end
    $finish;
  end

endmodule
